FILE: rtl/wpid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpid_pkg
// Shared types, constants and register map of the windowed pid position servo.
// ----------------------------------------------------------------------------
package wpid_pkg;

	localparam int SAMPLE_BITS = 10;
	localparam int WINDOW_LEN  = 400;
	localparam int RING_AW     = $clog2(WINDOW_LEN);

	localparam int ERR_LIMIT   = 32767;
	localparam int SUM_LIMIT   = 600000;
	localparam int DRIVE_LIMIT = 1500;

	localparam int DRIVE_W = 12;
	localparam int ERR_W   = 16;
	localparam int SUM_W   = 21;
	localparam int RES_W   = DRIVE_W + ERR_W + SUM_W;
	localparam int OUT_TW  = ((RES_W + 7) / 8) * 8;
	localparam int IN_TW   = ((2 * SAMPLE_BITS + 7) / 8) * 8;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam int PADDR_W = 5;

	// register indexes
	localparam logic [2:0] REG_PROP_GAIN       = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN      = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN      = 3'd2;
	localparam logic [2:0] REG_DRIVE_OFFSET    = 3'd3;
	localparam logic [2:0] REG_COMMAND_FLOOR   = 3'd4;
	localparam logic [2:0] REG_COMMAND_CEILING = 3'd5;
	localparam logic [2:0] REG_WRAP_SPAN       = 3'd6;
	localparam logic [2:0] REG_WRAP_THRESHOLD  = 3'd7;

	localparam logic [23:0] RST_PROP_GAIN       = 24'd393216;
	localparam logic [23:0] RST_INTEG_GAIN      = 24'd655;
	localparam logic [23:0] RST_DERIV_GAIN      = 24'd65536;
	localparam logic [10:0] RST_DRIVE_OFFSET    = 11'd100;
	localparam logic [9:0]  RST_COMMAND_FLOOR   = 10'd128;
	localparam logic [9:0]  RST_COMMAND_CEILING = 10'd700;
	localparam logic [11:0] RST_WRAP_SPAN       = 12'd758;
	localparam logic [9:0]  RST_WRAP_THRESHOLD  = 10'd333;

	typedef struct packed {
		logic [23:0] prop_gain;
		logic [23:0] integ_gain;
		logic [23:0] deriv_gain;
		logic [10:0] drive_offset;
		logic [9:0]  command_floor;
		logic [9:0]  command_ceiling;
		logic [11:0] wrap_span;
		logic [9:0]  wrap_threshold;
	} wpid_cfg_t;

endpackage
`default_nettype wire

FILE: rtl/wpid_cfg_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpid_cfg_regs
// Register bank behind the configuration port, write and read back.
// ----------------------------------------------------------------------------
module wpid_cfg_regs
	import wpid_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	output wpid_cfg_t               cfg
);

	wpid_cfg_t  cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain       <= RST_PROP_GAIN;
			cfg_q.integ_gain      <= RST_INTEG_GAIN;
			cfg_q.deriv_gain      <= RST_DERIV_GAIN;
			cfg_q.drive_offset    <= RST_DRIVE_OFFSET;
			cfg_q.command_floor   <= RST_COMMAND_FLOOR;
			cfg_q.command_ceiling <= RST_COMMAND_CEILING;
			cfg_q.wrap_span       <= RST_WRAP_SPAN;
			cfg_q.wrap_threshold  <= RST_WRAP_THRESHOLD;
		end else if (wr_en) begin
			unique case (idx)
				REG_PROP_GAIN:       cfg_q.prop_gain       <= pwdata[23:0];
				REG_INTEG_GAIN:      cfg_q.integ_gain      <= pwdata[23:0];
				REG_DERIV_GAIN:      cfg_q.deriv_gain      <= pwdata[23:0];
				REG_DRIVE_OFFSET:    cfg_q.drive_offset    <= pwdata[10:0];
				REG_COMMAND_FLOOR:   cfg_q.command_floor   <= pwdata[9:0];
				REG_COMMAND_CEILING: cfg_q.command_ceiling <= pwdata[9:0];
				REG_WRAP_SPAN:       cfg_q.wrap_span       <= pwdata[11:0];
				REG_WRAP_THRESHOLD:  cfg_q.wrap_threshold  <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_PROP_GAIN:       prdata = {8'b0, cfg_q.prop_gain};
			REG_INTEG_GAIN:      prdata = {8'b0, cfg_q.integ_gain};
			REG_DERIV_GAIN:      prdata = {8'b0, cfg_q.deriv_gain};
			REG_DRIVE_OFFSET:    prdata = {21'b0, cfg_q.drive_offset};
			REG_COMMAND_FLOOR:   prdata = {22'b0, cfg_q.command_floor};
			REG_COMMAND_CEILING: prdata = {22'b0, cfg_q.command_ceiling};
			REG_WRAP_SPAN:       prdata = {20'b0, cfg_q.wrap_span};
			REG_WRAP_THRESHOLD:  prdata = {22'b0, cfg_q.wrap_threshold};
			default:             prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/wpid_error_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpid_error_ring
// Ring of past errors in a synchronous memory: read at issue, written back at
// stage s2, with same-address forwarding and a fill flag for reset.
// ----------------------------------------------------------------------------
module wpid_error_ring
	import wpid_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    rd_en,
	input  wire logic                    wr_en,
	input  wire logic signed [ERR_W-1:0] wr_data,
	output logic signed      [ERR_W-1:0] past_s2
);

	logic signed [ERR_W-1:0] mem [WINDOW_LEN];

	logic [RING_AW-1:0]      pos_q;
	logic                    full_q;
	logic [RING_AW-1:0]      addr_s1;
	logic [RING_AW-1:0]      addr_s2;
	logic signed [ERR_W-1:0] rdata_s1;
	logic signed [ERR_W-1:0] fwd_data_s1;
	logic                    fwd_s1;
	logic                    filled_s1;
	logic                    pos_last;

	assign pos_last = (pos_q == RING_AW'(WINDOW_LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			full_q <= 1'b0;
		end else if (rd_en) begin
			if (pos_last) begin
				pos_q  <= '0;
				full_q <= 1'b1;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr_s2] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[pos_q];
		end
	end

	// a write landing on the entry being read in the same cycle is forwarded
	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1     <= pos_q;
			fwd_s1      <= wr_en && (addr_s2 == pos_q);
			fwd_data_s1 <= wr_data;
			filled_s1   <= full_q;
		end
		addr_s2 <= addr_s1;
		if (!filled_s1) begin
			past_s2 <= '0;
		end else if (fwd_s1) begin
			past_s2 <= fwd_data_s1;
		end else begin
			past_s2 <= rdata_s1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/wpid_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpid_out_fifo
// Result queue with credit count: input is taken only while a slot is
// reserved for every item in flight.
// ----------------------------------------------------------------------------
module wpid_out_fifo
	import wpid_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	output logic                   can_take,
	input  wire logic              wr_en,
	input  wire logic [RES_W-1:0]  wr_data,
	output logic                   rd_valid,
	input  wire logic              rd_ready,
	output logic      [RES_W-1:0]  rd_data
);

	logic [RES_W-1:0]   buf_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic [FIFO_AW:0]   credit_q;
	logic               pop;

	assign rd_valid = (count_q != '0);
	assign rd_data  = buf_q[rd_ptr_q];
	assign pop      = rd_valid && rd_ready;
	assign can_take = (credit_q < (FIFO_AW+1)'(FIFO_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			buf_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			credit_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q  <= count_q + (FIFO_AW+1)'(wr_en) - (FIFO_AW+1)'(pop);
			credit_q <= credit_q + (FIFO_AW+1)'(take && can_take) - (FIFO_AW+1)'(pop);
		end
	end

endmodule
`default_nettype wire

FILE: rtl/windowed_pid_position_servo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_pid_position_servo
// Position servo: sensor unwrap, clamped error, moving window integral, pid.
// ----------------------------------------------------------------------------
// usage
// s_* takes one item per control tick: command and measured sample.
// m_* gives one result item per input: drive, clamped error, window sum.
// the apb port holds gains, offset, command window and wrap settings; write
// it only while no item is in flight.
// a result passes stages s1 to s6, then the output queue, before m_tvalid.
// throughput: one item per cycle while s_tready is high, set by the rollover
// and window sum updates and the one read plus one write per cycle on the error ring.
// a receiver stall does not stop the pipeline: results queue in an 8-entry
// buffer and s_tready drops only once eight items are in flight or queued.
// reset: gains and limits take their defaults, the window sum clears, and
// the ring reads as zero until it has been filled once (fill flag, no
// clearing pass), so items are accepted from the first cycle after reset.
// ----------------------------------------------------------------------------
module windowed_pid_position_servo
	import wpid_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [IN_TW-1:0]   s_tdata,   // command_sample, actual_sample
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic      [OUT_TW-1:0]  m_tdata,   // drive_value, position_error, error_window_sum
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready
);

	localparam logic signed [30:0]        ERR_HI   = 31'(ERR_LIMIT);
	localparam logic signed [30:0]        ERR_LO   = -31'(ERR_LIMIT);
	localparam logic signed [22:0]        SUM_HI   = 23'(SUM_LIMIT);
	localparam logic signed [22:0]        SUM_LO   = -23'(SUM_LIMIT);
	localparam logic [32:0]               DRV_MAX  = 33'(DRIVE_LIMIT);
	localparam logic signed [15:0]        ROLL_MAX = 16'sh7FFF;
	localparam logic signed [15:0]        ROLL_MIN = 16'sh8000;

	wpid_cfg_t cfg;

	wpid_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic in_acc;
	assign in_acc = s_tvalid && s_tready;

	// ---------------- issue: unwrap tracking and command clamp
	logic [SAMPLE_BITS-1:0] cmd_in;
	logic [SAMPLE_BITS-1:0] act_in;
	logic                   first_q;
	logic [SAMPLE_BITS-1:0] prev_q;
	logic signed [15:0]     roll_q;
	logic signed [15:0]     roll_next;
	logic signed [SAMPLE_BITS+1:0] jump;
	logic signed [SAMPLE_BITS+1:0] thr;
	logic [9:0]             cmd_lo;
	logic [9:0]             cmd_cl;

	assign cmd_in = s_tdata[SAMPLE_BITS-1:0];
	assign act_in = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign thr    = $signed({2'b0, cfg.wrap_threshold});
	assign jump   = first_q ? '0 : ($signed({2'b0, act_in}) - $signed({2'b0, prev_q}));

	always_comb begin
		roll_next = roll_q;
		if ((jump < -thr) && (roll_q != ROLL_MAX)) begin
			roll_next = roll_q + 16'sd1;
		end else if ((jump > thr) && (roll_q != ROLL_MIN)) begin
			roll_next = roll_q - 16'sd1;
		end
		cmd_lo = (10'(cmd_in) < cfg.command_floor) ? cfg.command_floor : 10'(cmd_in);
		cmd_cl = (cmd_lo > cfg.command_ceiling) ? cfg.command_ceiling : cmd_lo;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b1;
			prev_q  <= '0;
			roll_q  <= '0;
		end else if (in_acc) begin
			first_q <= 1'b0;
			prev_q  <= act_in;
			roll_q  <= roll_next;
		end
	end

	// stage valids
	logic v1_s1, v2_s2, v3_s3, v4_s4, v5_s5, v6_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			v5_s5 <= 1'b0;
			v6_s6 <= 1'b0;
		end else begin
			v1_s1 <= in_acc;
			v2_s2 <= v1_s1;
			v3_s3 <= v2_s2;
			v4_s4 <= v3_s3;
			v5_s5 <= v4_s4;
			v6_s6 <= v5_s5;
		end
	end

	// ---------------- s1: rollover offset
	logic signed [15:0]      roll_s1;
	logic [SAMPLE_BITS-1:0]  act_s1;
	logic [9:0]              cmd_s1;
	logic signed [28:0]      unwrap_prod;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			roll_s1 <= roll_next;
			act_s1  <= act_in;
			cmd_s1  <= cmd_cl;
		end
	end

	assign unwrap_prod = roll_s1 * $signed({1'b0, cfg.wrap_span});

	// ---------------- s2: error and ring write-back
	logic signed [28:0]      prod_s2;
	logic [SAMPLE_BITS-1:0]  act_s2;
	logic [9:0]              cmd_s2;
	logic signed [30:0]      diff;
	logic signed [ERR_W-1:0] err_c;
	logic signed [ERR_W-1:0] past_s2;

	always_ff @(posedge clk) begin
		prod_s2 <= unwrap_prod;
		act_s2  <= act_s1;
		cmd_s2  <= cmd_s1;
	end

	always_comb begin
		diff = 31'(prod_s2) + $signed(31'(act_s2)) - $signed(31'(cmd_s2));
		if (diff > ERR_HI) begin
			err_c = ERR_W'(ERR_HI);
		end else if (diff < ERR_LO) begin
			err_c = ERR_W'(ERR_LO);
		end else begin
			err_c = diff[ERR_W-1:0];
		end
	end

	wpid_error_ring u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (in_acc),
		.wr_en   (v2_s2),
		.wr_data (err_c),
		.past_s2 (past_s2)
	);

	// ---------------- s3: window sum and difference
	logic signed [ERR_W-1:0] err_s3;
	logic signed [ERR_W-1:0] past_s3;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [22:0]      sum_raw;
	logic signed [SUM_W-1:0] sum_c;

	always_ff @(posedge clk) begin
		err_s3  <= err_c;
		past_s3 <= past_s2;
	end

	always_comb begin
		sum_raw = 23'(sum_q) + 23'(err_s3) - 23'(past_s3);
		if (sum_raw > SUM_HI) begin
			sum_c = SUM_W'(SUM_HI);
		end else if (sum_raw < SUM_LO) begin
			sum_c = SUM_W'(SUM_LO);
		end else begin
			sum_c = sum_raw[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (v3_s3) begin
			sum_q <= sum_c;
		end
	end

	// ---------------- s4: gain products
	logic signed [ERR_W-1:0] err_s4;
	logic signed [SUM_W-1:0] sum_s4;
	logic signed [16:0]      der_s4;

	always_ff @(posedge clk) begin
		err_s4 <= err_s3;
		sum_s4 <= sum_c;
		der_s4 <= 17'(err_s3) - 17'(past_s3);
	end

	logic signed [40:0]      pp_s5;
	logic signed [45:0]      pi_s5;
	logic signed [41:0]      pd_s5;
	logic signed [ERR_W-1:0] err_s5;
	logic signed [SUM_W-1:0] sum_s5;

	always_ff @(posedge clk) begin
		pp_s5  <= $signed({1'b0, cfg.prop_gain}) * err_s4;
		pi_s5  <= $signed({1'b0, cfg.integ_gain}) * sum_s4;
		pd_s5  <= $signed({1'b0, cfg.deriv_gain}) * der_s4;
		err_s5 <= err_s4;
		sum_s5 <= sum_s4;
	end

	// ---------------- s5: accumulate
	logic signed [47:0]      acc_s6;
	logic signed [ERR_W-1:0] err_s6;
	logic signed [SUM_W-1:0] sum_s6;

	always_ff @(posedge clk) begin
		acc_s6 <= 48'(pp_s5) + 48'(pi_s5) + 48'(pd_s5);
		err_s6 <= err_s5;
		sum_s6 <= sum_s5;
	end

	// ---------------- s6: offset away from zero and saturation
	logic                      acc_pos;
	logic signed [47:0]        acc_mag;
	logic [32:0]               mag_sum;
	logic [10:0]               mag_sat;
	logic signed [DRIVE_W-1:0] drive_c;

	always_comb begin
		acc_pos = !acc_s6[47] && (acc_s6 != '0);
		acc_mag = acc_pos ? acc_s6 : -acc_s6;
		mag_sum = {1'b0, acc_mag[47:16]} + 33'(cfg.drive_offset);
		mag_sat = (mag_sum > DRV_MAX) ? 11'(DRV_MAX) : mag_sum[10:0];
		drive_c = acc_pos ? -$signed({1'b0, mag_sat}) : $signed({1'b0, mag_sat});
	end

	logic [RES_W-1:0] res_c;
	logic [RES_W-1:0] res_out;

	assign res_c = {sum_s6, err_s6, drive_c};

	wpid_out_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (s_tvalid),
		.can_take (s_tready),
		.wr_en    (v6_s6),
		.wr_data  (res_c),
		.rd_valid (m_tvalid),
		.rd_ready (m_tready),
		.rd_data  (res_out)
	);

	assign m_tdata = {(OUT_TW-RES_W)'(0), res_out};

endmodule
`default_nettype wire

FILE: rtl/wpid_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wpid_checker
// Port-level checks on the servo's result stream and flow control.
// ----------------------------------------------------------------------------
module wpid_checker
	import wpid_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              s_tready,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [OUT_TW-1:0] m_tdata
);

	logic signed [DRIVE_W-1:0] drive;
	logic signed [SUM_W-1:0]   wsum;

	assign drive = m_tdata[DRIVE_W-1:0];
	assign wsum  = m_tdata[RES_W-1:DRIVE_W+ERR_W];

	// a stalled result item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (drive <= 12'sd1500) && (drive >= -12'sd1500))
		else $error("drive out of range");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (wsum <= 21'sd600000) && (wsum >= -21'sd600000))
		else $error("window sum out of range");

	// credits run out only once the pipeline has pushed results into the queue
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input blocked with no result pending");

endmodule

bind windowed_pid_position_servo wpid_checker u_wpid_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

FILE: test/windowed_pid_position_servo_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// windowed_pid_position_servo_test
// Self-checking bench for the servo. Sample pairs go into the stream input in
// bursts while the result side stalls on its own pattern. A scoreboard
// predicts drive, clamped error and window sum for every accepted pair, and
// the configuration is changed between phases, register read-back included.
// A closing sweep with a zero threshold counts rollovers up on a falling ramp
// and back down on a rising one.
// ----------------------------------------------------------------------------
module windowed_pid_position_servo_test
	import wpid_pkg::*;
;

	localparam int ERR_LSB = DRIVE_W;
	localparam int SUM_LSB = DRIVE_W + ERR_W;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		logic signed [ERR_W-1:0]   err;
		logic signed [SUM_W-1:0]   window_sum;
	} servo_result_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_t;

	class drive_scoreboard;
		wpid_cfg_t     cfg;
		bit            first_sample;
		logic [9:0]    prev_actual;
		shortint       turns;
		shortint       err_ring[WINDOW_LEN];
		int            ring_pos;
		longint        window_sum;
		int            results_seen;
		servo_result_t pending_results[$];

		function new();
			cfg = '{prop_gain: RST_PROP_GAIN, integ_gain: RST_INTEG_GAIN,
				deriv_gain: RST_DERIV_GAIN, drive_offset: RST_DRIVE_OFFSET,
				command_floor: RST_COMMAND_FLOOR, command_ceiling: RST_COMMAND_CEILING,
				wrap_span: RST_WRAP_SPAN, wrap_threshold: RST_WRAP_THRESHOLD};
			first_sample = 1'b1;
			prev_actual = '0;
			turns = 0;
			foreach (err_ring[i]) err_ring[i] = 0;
			ring_pos = 0;
			window_sum = 0;
			results_seen = 0;
		endfunction

		function longint clamp(longint v, longint lim);
			if (v < -lim) return -lim;
			if (v > lim) return lim;
			return v;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] v);
			case (idx)
				REG_PROP_GAIN:       cfg.prop_gain = v[23:0];
				REG_INTEG_GAIN:      cfg.integ_gain = v[23:0];
				REG_DERIV_GAIN:      cfg.deriv_gain = v[23:0];
				REG_DRIVE_OFFSET:    cfg.drive_offset = v[10:0];
				REG_COMMAND_FLOOR:   cfg.command_floor = v[9:0];
				REG_COMMAND_CEILING: cfg.command_ceiling = v[9:0];
				REG_WRAP_SPAN:       cfg.wrap_span = v[11:0];
				REG_WRAP_THRESHOLD:  cfg.wrap_threshold = v[9:0];
				default: ;
			endcase
		endfunction

		function logic [31:0] reg_value(logic [2:0] idx);
			case (idx)
				REG_PROP_GAIN:       return 32'(cfg.prop_gain);
				REG_INTEG_GAIN:      return 32'(cfg.integ_gain);
				REG_DERIV_GAIN:      return 32'(cfg.deriv_gain);
				REG_DRIVE_OFFSET:    return 32'(cfg.drive_offset);
				REG_COMMAND_FLOOR:   return 32'(cfg.command_floor);
				REG_COMMAND_CEILING: return 32'(cfg.command_ceiling);
				REG_WRAP_SPAN:       return 32'(cfg.wrap_span);
				default:             return 32'(cfg.wrap_threshold);
			endcase
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void note_sample_pair(logic [IN_TW-1:0] d);
			longint        cmd, act, jump, position, err, past, der, acc, drv;
			servo_result_t r;
			cmd = longint'(d[9:0]);
			act = longint'(d[19:10]);
			// no jump is seen on the very first sample
			jump = first_sample ? 0 : act - longint'(prev_actual);
			prev_actual = d[19:10];
			first_sample = 1'b0;
			if (jump < -longint'(cfg.wrap_threshold) && turns < 32767) turns++;
			if (jump > longint'(cfg.wrap_threshold) && turns > -32768) turns--;
			position = longint'(turns) * longint'(cfg.wrap_span) + act;
			// floor first, so the ceiling wins when they cross
			if (cmd < longint'(cfg.command_floor)) cmd = longint'(cfg.command_floor);
			if (cmd > longint'(cfg.command_ceiling)) cmd = longint'(cfg.command_ceiling);
			err = clamp(position - cmd, ERR_LIMIT);
			past = err_ring[ring_pos];
			window_sum = clamp(window_sum + err - past, SUM_LIMIT);
			err_ring[ring_pos] = shortint'(err);
			ring_pos = (ring_pos + 1) % WINDOW_LEN;
			der = err - past;
			acc = longint'(cfg.prop_gain) * err + longint'(cfg.integ_gain) * window_sum
				+ longint'(cfg.deriv_gain) * der;
			if (acc > 0)
				drv = -((acc >>> 16) + longint'(cfg.drive_offset));
			else
				drv = ((-acc) >>> 16) + longint'(cfg.drive_offset);
			drv = clamp(drv, DRIVE_LIMIT);
			r.drive = drv[DRIVE_W-1:0];
			r.err = err[ERR_W-1:0];
			r.window_sum = window_sum[SUM_W-1:0];
			pending_results.push_back(r);
		endfunction

		function string check_drive_item(logic [OUT_TW-1:0] d);
			servo_result_t e;
			string         why;
			why = "";
			results_seen++;
			if (pending_results.size() == 0)
				return $sformatf("result %0d arrived with no item pending", results_seen);
			e = pending_results.pop_front();
			if (d[DRIVE_W-1:0] !== e.drive)
				why = {why, $sformatf(" drive %0d exp %0d",
					$signed(d[DRIVE_W-1:0]), e.drive)};
			if (d[ERR_LSB +: ERR_W] !== e.err)
				why = {why, $sformatf(" error %0d exp %0d",
					$signed(d[ERR_LSB +: ERR_W]), e.err)};
			if (d[SUM_LSB +: SUM_W] !== e.window_sum)
				why = {why, $sformatf(" sum %0d exp %0d",
					$signed(d[SUM_LSB +: SUM_W]), e.window_sum)};
			if (why != "") why = {$sformatf("result %0d:", results_seen), why};
			return why;
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [IN_TW-1:0]   s_tdata;   // command_sample, actual_sample
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OUT_TW-1:0]  m_tdata;   // drive_value, position_error, error_window_sum
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	drive_scoreboard sb;
	int              mismatches = 0;
	string           why;
	int              burst_left = 0;
	logic [9:0]      walk_act = 10'd400;
	bit              rx_fast = 1'b0;
	rx_mode_t        rx_mode = RX_OPEN;
	int              rx_left = 0;

	windowed_pid_position_servo dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50) $display("%0t mismatch: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.note_sample_pair(s_tdata);
			if (m_tvalid && m_tready) begin
				why = sb.check_drive_item(m_tdata);
				if (why != "") report_mismatch(why);
			end
		end
	end

	// receiver: switches between open, coin-toss, sparse and long-stall stretches
	always @(negedge clk) begin
		if (rx_fast) begin
			m_tready <= 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(32, 256);
			end
			rx_left--;
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= ((rx_left % 48) >= 40);
			endcase
		end
	end

	task automatic send_item(input logic [9:0] cmd, input logic [9:0] act);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= IN_TW'({act, cmd});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic pause(input int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'({idx, 2'b00});
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_reg(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reg_check(input logic [2:0] idx);
		logic [31:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= PADDR_W'({idx, 2'b00});
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== sb.reg_value(idx))
			report_mismatch($sformatf("register %0d reads %0h exp %0h",
				idx, got, sb.reg_value(idx)));
	endtask

	task automatic apply_setting(input wpid_cfg_t c);
		reg_write(REG_PROP_GAIN, 32'(c.prop_gain));
		reg_write(REG_INTEG_GAIN, 32'(c.integ_gain));
		reg_write(REG_DERIV_GAIN, 32'(c.deriv_gain));
		reg_write(REG_DRIVE_OFFSET, 32'(c.drive_offset));
		reg_write(REG_COMMAND_FLOOR, 32'(c.command_floor));
		reg_write(REG_COMMAND_CEILING, 32'(c.command_ceiling));
		reg_write(REG_WRAP_SPAN, 32'(c.wrap_span));
		reg_write(REG_WRAP_THRESHOLD, 32'(c.wrap_threshold));
		for (int i = 0; i < 8; i++) reg_check(3'(i));
	endtask

	function automatic wpid_cfg_t random_setting();
		wpid_cfg_t c;
		bit        wide;
		wide = ($urandom_range(0, 4) == 0);
		c.prop_gain = wide ? 24'($urandom) : 24'($urandom_range(0, 1 << 19));
		c.integ_gain = wide ? 24'($urandom) : 24'($urandom_range(0, 4000));
		c.deriv_gain = wide ? 24'($urandom) : 24'($urandom_range(0, 1 << 18));
		c.drive_offset = 11'($urandom_range(0, 1500));
		c.command_floor = 10'($urandom_range(0, 600));
		c.command_ceiling = ($urandom_range(0, 5) == 0) ? 10'($urandom_range(0, 1023))
			: 10'($urandom_range(c.command_floor, 1023));
		c.wrap_span = 12'($urandom_range(0, 4095));
		c.wrap_threshold = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
			: 10'($urandom_range(200, 700));
		return c;
	endfunction

	// wait for every result, then leave the block quiet
	task automatic settle();
		int waited;
		waited = 0;
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sb.pending() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		if (sb.pending() != 0)
			report_mismatch($sformatf("%0d results never arrived", sb.pending()));
		repeat (8) @(posedge clk);
	endtask

	// mostly a slowly moving sensor that wraps now and then, some noise on top
	task automatic run_random(input int n);
		logic [9:0] cmd, act;
		for (int i = 0; i < n; i++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
			end
			burst_left--;
			if ($urandom_range(0, 9) < 7) begin
				walk_act = walk_act + 10'($urandom_range(0, 48)) - 10'd24;
				act = walk_act;
			end else begin
				act = 10'($urandom);
			end
			case ($urandom_range(0, 9))
				0:       cmd = '0;
				1:       cmd = '1;
				2:       cmd = 10'($urandom);
				default: cmd = walk_act + 10'($urandom_range(0, 64)) - 10'd32;
			endcase
			send_item(cmd, act);
		end
	endtask

	// threshold zero: a falling ramp counts up on every step, a rising one down
	task automatic run_rollover_sweep();
		wpid_cfg_t c;
		int        idx;
		c = '{prop_gain: RST_PROP_GAIN, integ_gain: RST_INTEG_GAIN,
			deriv_gain: RST_DERIV_GAIN, drive_offset: RST_DRIVE_OFFSET,
			command_floor: '0, command_ceiling: '1,
			wrap_span: 12'($urandom_range(1, 4095)), wrap_threshold: '0};
		apply_setting(c);
		rx_fast = 1'b1;
		idx = 0;
		repeat (16) begin
			send_item(10'($urandom), 10'(1023 - idx % 1024));
			idx++;
		end
		idx = 0;
		repeat (24) begin
			send_item(10'($urandom), 10'(idx % 1024));
			idx++;
		end
		settle();
		rx_fast = 1'b0;
	endtask

	initial begin
		wpid_cfg_t c;
		sb = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values: first sample never counts a jump, threshold edges
		for (int i = 0; i < 8; i++) reg_check(3'(i));
		send_item(10'd0, 10'd1023);
		send_item(10'd1023, 10'd0);
		send_item(10'd128, 10'd1023);
		send_item(10'd127, 10'd690);
		send_item(10'd700, 10'd356);
		send_item(10'd701, 10'd689);
		send_item(10'd512, 10'd1023);
		send_item(10'd1023, 10'd0);
		run_random(300);
		settle();

		// top extremes, floor above ceiling so the ceiling wins
		c = '{prop_gain: '1, integ_gain: '1, deriv_gain: '1, drive_offset: 11'd1500,
			command_floor: '1, command_ceiling: '0, wrap_span: '1, wrap_threshold: '1};
		apply_setting(c);
		send_item(10'd0, 10'd0);
		send_item(10'd1023, 10'd1023);
		send_item(10'd512, 10'd0);
		run_random(250);
		settle();

		// bottom extremes: no gain, no offset, every sensor step a rollover
		c = '{prop_gain: '0, integ_gain: '0, deriv_gain: '0, drive_offset: '0,
			command_floor: '0, command_ceiling: '1, wrap_span: '0, wrap_threshold: '0};
		apply_setting(c);
		send_item(10'd5, 10'd5);
		send_item(10'd0, 10'd4);
		send_item(10'd1023, 10'd5);
		run_random(250);
		settle();

		// zero correction still drives plus the offset
		reg_write(REG_DRIVE_OFFSET, 32'd1500);
		reg_check(REG_DRIVE_OFFSET);
		send_item(10'd7, 10'd7);
		send_item(10'd7, 10'd6);
		settle();

		repeat (4) begin
			apply_setting(random_setting());
			run_random(260);
			settle();
		end

		run_rollover_sweep();

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#20000000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/wpid_pkg.sv
rtl/wpid_cfg_regs.sv
rtl/wpid_error_ring.sv
rtl/wpid_out_fifo.sv
rtl/windowed_pid_position_servo.sv
rtl/wpid_checker.sv
test/windowed_pid_position_servo_test.sv
